FILE: hdl/tile_palette_indexer_macros.svh
// ----------------------------------------------------------------------------
// tile_palette_indexer assertion macros
// shared property wrappers for the block's checker
// ----------------------------------------------------------------------------
`ifndef TILE_PALETTE_INDEXER_MACROS_SVH
`define TILE_PALETTE_INDEXER_MACROS_SVH

// condition implies consequence in the same cycle
`define TPI_ASSERT_NOW(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define TPI_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tpi_pkg.sv
// ----------------------------------------------------------------------------
// tpi_pkg
// types and constants of the tile palette indexer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpi_pkg;

  // hard limit on palette slots, set by the 4-bit slot fields
  localparam int SLOT_MAX = 16;

  localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ALPHA = 2'd1,
    ST_TOO_MANY  = 2'd2
  } status_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_ENTRY = 1'b1
  } kind_e;

  // one input pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       tile_end;
  } pixel_t;

  // one result item
  typedef struct packed {
    kind_e       item_kind;
    logic [3:0]  pixel_index;
    logic [14:0] color_word;
    logic [3:0]  entry_number;
    logic [4:0]  palette_size;
    status_e     status;
    logic        last;
  } result_t;

  // palette write request
  typedef struct packed {
    logic        en;
    logic [3:0]  slot;
    logic [14:0] color;
  } pal_wr_t;

  // palette lookup outcome
  typedef struct packed {
    logic       found;
    logic [3:0] slot;
  } pal_match_t;

endpackage

FILE: hdl/tpi_palette.sv
// ----------------------------------------------------------------------------
// tpi_palette
// palette color store with parallel match over the filled slots
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpi_palette #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                clk_i,
  input  tpi_pkg::pal_wr_t    wr_i,
  input  logic [14:0]         color_i,
  input  logic [4:0]          count_i,
  output tpi_pkg::pal_match_t match_o,
  input  logic [3:0]          rd_slot_i,
  output logic [14:0]         rd_color_o
);
  import tpi_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);

  // slot 0 is the transparent slot and is never stored
  logic [14:0] pal_q [NUM_SLOTS];

  // append a new color
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      pal_q[wr_i.slot[SW-1:0]] <= wr_i.color;
    end
  end

  // compare against every filled slot, lowest match wins
  always_comb begin
    match_o = '0;
    for (int i = 1; i < NUM_SLOTS; i++) begin
      if (!match_o.found && (5'(i) < count_i) && (pal_q[i] == color_i)) begin
        match_o.found = 1'b1;
        match_o.slot  = 4'(i);
      end
    end
  end

  // entry read for the end-of-tile dump
  assign rd_color_o = pal_q[rd_slot_i[SW-1:0]];

endmodule

FILE: hdl/tile_palette_indexer.sv
// ----------------------------------------------------------------------------
// tile_palette_indexer
// builds a per-tile BGR555 palette and maps each pixel to a palette slot
// ----------------------------------------------------------------------------
// Accepts one RGBA pixel per cycle unless the output stalls or a palette
// dump runs; each pixel yields one pixel result, through the input and
// output registers. Opaque colors are reduced to BGR555 and matched in
// parallel against the filled palette slots. A tile's last pixel result is
// followed by one palette entry item per stored color (palette_size - 1
// items, up to 15), read from the store one slot a cycle unless the output
// stalls, with the next pixel held in the input register. Errors (invalid
// alpha, too many colors) stick until the tile ends.
// Capacity is min(PALETTE_ENTRIES, 16) slots including the transparent slot.
`timescale 1ns / 1ps

module tile_palette_indexer #(
  parameter int PALETTE_ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tpi_pkg::pixel_t  in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tpi_pkg::result_t out_item_o
);
  import tpi_pkg::*;

  localparam int NumSlots = (PALETTE_ENTRIES > SLOT_MAX) ? SLOT_MAX : PALETTE_ENTRIES;
  localparam logic [4:0] CapW = 5'(NumSlots);

  logic        s1_valid_q, s1_valid_d;
  pixel_t      s1_q;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;
  logic        emit_q, emit_d;
  logic [3:0]  slot_q, slot_d;
  logic [4:0]  count_q, count_d;
  status_e     err_q, err_d;

  logic        out_load, proc, emit_go, entry_last;
  logic [14:0] bgr, rd_color;
  pal_match_t  match;
  pal_wr_t     wr;
  logic [3:0]  pix_idx;
  logic [4:0]  pix_count;
  status_e     pix_err;

  // handshake
  assign out_load   = !out_valid_q || !out_stall_i;
  assign proc       = s1_valid_q && out_load && !emit_q;
  assign emit_go    = emit_q && out_load;
  assign in_stall_o = s1_valid_q && !proc;

  assign bgr = {s1_q.blue[7:3], s1_q.green[7:3], s1_q.red[7:3]};

  tpi_palette #(
    .NUM_SLOTS (NumSlots)
  ) u_palette (
    .clk_i      (clk_i),
    .wr_i       (wr),
    .color_i    (bgr),
    .count_i    (count_q),
    .match_o    (match),
    .rd_slot_i  (slot_q),
    .rd_color_o (rd_color)
  );

  // pixel classification and palette append
  always_comb begin
    pix_idx   = '0;
    pix_count = count_q;
    pix_err   = err_q;
    wr.en     = 1'b0;
    wr.slot   = count_q[3:0];
    wr.color  = bgr;
    if (err_q == ST_OK) begin
      if (s1_q.alpha == ALPHA_CLEAR) begin
        pix_idx = '0;
      end else if (s1_q.alpha == ALPHA_OPAQUE) begin
        if (match.found) begin
          pix_idx = match.slot;
        end else if (count_q >= CapW) begin
          pix_err = ST_TOO_MANY;
        end else begin
          wr.en     = proc;
          pix_idx   = count_q[3:0];
          pix_count = count_q + 5'd1;
        end
      end else begin
        pix_err = ST_BAD_ALPHA;
      end
    end
  end

  assign entry_last = (({1'b0, slot_q} + 5'd1) == count_q);

  // next state and result register
  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    emit_d      = emit_q;
    slot_d      = slot_q;
    count_d     = count_q;
    err_d       = err_q;
    if (proc) begin
      s1_valid_d = 1'b0;
    end
    if (in_valid_i && !in_stall_o) begin
      s1_valid_d = 1'b1;
    end
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (proc) begin
      out_valid_d        = 1'b1;
      out_d.item_kind    = KIND_PIXEL;
      out_d.pixel_index  = pix_idx;
      out_d.color_word   = '0;
      out_d.entry_number = '0;
      out_d.palette_size = pix_count;
      out_d.status       = pix_err;
      out_d.last         = !(s1_q.tile_end && (pix_count > 5'd1));
      if (s1_q.tile_end && (pix_count > 5'd1)) begin
        emit_d  = 1'b1;
        slot_d  = 4'd1;
        count_d = pix_count;
        err_d   = pix_err;
      end else if (s1_q.tile_end) begin
        count_d = 5'd1;
        err_d   = ST_OK;
      end else begin
        count_d = pix_count;
        err_d   = pix_err;
      end
    end else if (emit_go) begin
      out_valid_d        = 1'b1;
      out_d.item_kind    = KIND_ENTRY;
      out_d.pixel_index  = '0;
      out_d.color_word   = rd_color;
      out_d.entry_number = slot_q;
      out_d.palette_size = count_q;
      out_d.status       = err_q;
      out_d.last         = entry_last;
      slot_d             = slot_q + 4'd1;
      if (entry_last) begin
        emit_d  = 1'b0;
        count_d = 5'd1;
        err_d   = ST_OK;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      emit_q      <= 1'b0;
      slot_q      <= '0;
      count_q     <= 5'd1;
      err_q       <= ST_OK;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      emit_q      <= emit_d;
      slot_q      <= slot_d;
      count_q     <= count_d;
      err_q       <= err_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_q <= in_item_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: hdl/tpi_checker.sv
// ----------------------------------------------------------------------------
// tpi_checker
// port-level checks of the tile palette indexer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tile_palette_indexer_macros.svh"

module tpi_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input tpi_pkg::pixel_t  in_item_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input tpi_pkg::result_t out_item_o
);
  import tpi_pkg::*;

  // a stalled result item holds
  `TPI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o), "stalled result item changed")

  // a pixel with a nonzero slot can only come from an error-free tile
  `TPI_ASSERT_NOW(a_idx_ok, clk_i, rst_ni, out_valid_o && (out_item_o.item_kind == KIND_PIXEL) && (out_item_o.pixel_index != 4'd0), out_item_o.status == ST_OK, "indexed pixel carries an error status")

  // palette entries name a filled slot
  `TPI_ASSERT_NOW(a_entry_slot, clk_i, rst_ni, out_valid_o && (out_item_o.item_kind == KIND_ENTRY), (out_item_o.entry_number != 4'd0) && ({1'b0, out_item_o.entry_number} < out_item_o.palette_size) && (out_item_o.pixel_index == 4'd0), "palette entry outside the filled slots")

  // a pixel item is only followed by entries when colors are stored
  `TPI_ASSERT_NOW(a_pix_last, clk_i, rst_ni, out_valid_o && (out_item_o.item_kind == KIND_PIXEL) && !out_item_o.last, out_item_o.palette_size > 5'd1, "entry dump announced for an empty palette")

  // input side is not otherwise checked here
  logic unused_in;
  assign unused_in = in_valid_i ^ in_stall_o ^ (^in_item_i);

endmodule

bind tile_palette_indexer tpi_checker u_tpi_checker (.*);

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the tile palette indexer
// ----------------------------------------------------------------------------
// Streams RGBA pixels into the block and checks every pixel result and every
// palette entry item against a cycle-free palette builder kept in the bench.
// A short directed run covers the alpha extremes, color reduction, palette
// overflow and sticky errors, then random tiles follow, mostly well-formed
// with small color pools, plus overflow tiles and noise. Both handshakes
// idle at random except for one quiet stretch.
`timescale 1ns / 1ps

module tb_top;
  import tpi_pkg::*;

  localparam int PAL_CAP         = 16;
  localparam int RANDOM_PIXELS   = 500;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES   = 32;
  localparam int REPORT_MAX      = 10;

  // one pending pixel, optionally held back until all results are in
  typedef struct {
    pixel_t px;
    bit     drain_first;
  } pixel_req_t;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_stall;
  pixel_t  in_item   = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  result_t out_item;

  pixel_req_t  pixel_q[$];
  result_t     expected_q[$];

  // palette builder state
  logic [14:0] pal_color[PAL_CAP];
  int          pal_count = 1;
  status_e     tile_err  = ST_OK;

  logic px_taken     = 1'b0;
  int   stuck_cycles = 0;
  int   mismatch_count;
  int   pixels_seen, results_seen, entries_seen, tiles_seen;
  int   bad_alpha_tiles, overflow_tiles;

  tile_palette_indexer #(
    .PALETTE_ENTRIES(PAL_CAP)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always #1 clk = ~clk;

  // index one pixel and queue the items it must produce
  function automatic void index_pixel(input pixel_t px);
    logic [14:0] bgr;
    int          slot;
    int          found;
    result_t     res;
    bgr   = {px.blue[7:3], px.green[7:3], px.red[7:3]};
    slot  = 0;
    found = 0;
    if (tile_err == ST_OK) begin
      if (px.alpha == ALPHA_OPAQUE) begin
        for (int s = 1; s < pal_count; s++) begin
          if (found == 0 && pal_color[s] == bgr) found = s;
        end
        if (found != 0) begin
          slot = found;
        end else if (pal_count >= PAL_CAP) begin
          tile_err = ST_TOO_MANY;
        end else begin
          pal_color[pal_count] = bgr;
          slot = pal_count;
          pal_count++;
        end
      end else if (px.alpha != ALPHA_CLEAR) begin
        tile_err = ST_BAD_ALPHA;
      end
    end
    res              = '0;
    res.item_kind    = KIND_PIXEL;
    res.pixel_index  = 4'(slot);
    res.palette_size = 5'(pal_count);
    res.status       = tile_err;
    res.last         = px.tile_end ? (pal_count <= 1) : 1'b1;
    expected_q = {expected_q, res};
    // tile end: dump the palette, then start over
    if (px.tile_end) begin
      for (int s = 1; s < pal_count; s++) begin
        res              = '0;
        res.item_kind    = KIND_ENTRY;
        res.color_word   = pal_color[s];
        res.entry_number = 4'(s);
        res.palette_size = 5'(pal_count);
        res.status       = tile_err;
        res.last         = (s + 1 == pal_count);
        expected_q = {expected_q, res};
      end
      tiles_seen++;
      if (tile_err == ST_BAD_ALPHA) bad_alpha_tiles++;
      if (tile_err == ST_TOO_MANY) overflow_tiles++;
      pal_count = 1;
      tile_err  = ST_OK;
    end
  endfunction

  // compare one received item with the oldest expected one
  function automatic void check_result(input result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("unexpected item: kind %0d index %0d color %h entry %0d size %0d st %0d",
                 got.item_kind, got.pixel_index, got.color_word, got.entry_number,
                 got.palette_size, got.status);
    end else begin
      want = expected_q.pop_front();
      if (got.item_kind !== want.item_kind || got.pixel_index !== want.pixel_index ||
          got.color_word !== want.color_word || got.entry_number !== want.entry_number ||
          got.palette_size !== want.palette_size || got.status !== want.status ||
          got.last !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("mismatch on item %0d at %0t", results_seen, $realtime);
          $display("  expected kind %0d index %0d color %h entry %0d size %0d st %0d last %0d",
                   want.item_kind, want.pixel_index, want.color_word, want.entry_number,
                   want.palette_size, want.status, want.last);
          $display("  actual   kind %0d index %0d color %h entry %0d size %0d st %0d last %0d",
                   got.item_kind, got.pixel_index, got.color_word, got.entry_number,
                   got.palette_size, got.status, got.last);
        end
      end
    end
    results_seen++;
    if (got.item_kind == KIND_ENTRY) entries_seen++;
  endfunction

  function automatic void add_pixel(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b, input logic [7:0] a,
                                    input logic last_px, input bit drain);
    pixel_req_t req;
    req.px          = '{red: r, green: g, blue: b, alpha: a, tile_end: last_px};
    req.drain_first = drain;
    pixel_q = {pixel_q, req};
  endfunction

  // quiet stretch with no idling on either side
  function automatic bit quiet_now();
    return pixels_seen >= 150 && pixels_seen < 250;
  endfunction

  // sample both handshakes and keep the watchdog count
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      px_taken     <= 1'b0;
      stuck_cycles <= 0;
    end else begin
      px_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        index_pixel(in_item);
        pixels_seen++;
      end
      if (out_valid && !out_stall) check_result(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
    end
  end

  // pixel driver and result-side stall, both on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || px_taken) begin
        if (pixel_q.size() != 0 && pixel_q[0].drain_first && expected_q.size() != 0) begin
          in_valid <= 1'b0;
        end else if (pixel_q.size() != 0 && (quiet_now() || $urandom_range(99) >= 34)) begin
          in_item  <= pixel_q[0].px;
          in_valid <= 1'b1;
          void'(pixel_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !quiet_now() && ($urandom_range(99) < 34);
    end
  end

  // stimulus, reset and end of run
  initial begin
    int          mode, pool_n, len, rand_count, pick;
    logic [23:0] pool[20];
    logic [23:0] c;
    logic [7:0]  a;
    bit          drain;

    // transparent-only tile
    add_pixel(8'h12, 8'h34, 8'h56, ALPHA_CLEAR, 1'b1, 1'b0);
    // white, black, white again after reduction, transparent tile end
    add_pixel(8'hFF, 8'hFF, 8'hFF, ALPHA_OPAQUE, 1'b0, 1'b0);
    add_pixel(8'h00, 8'h00, 8'h00, ALPHA_OPAQUE, 1'b0, 1'b0);
    add_pixel(8'hF8, 8'hF8, 8'hF8, ALPHA_OPAQUE, 1'b0, 1'b0);
    add_pixel(8'h07, 8'h00, 8'h00, ALPHA_CLEAR, 1'b1, 1'b0);
    // invalid alpha sticks to the end of the tile
    add_pixel(8'hA0, 8'h50, 8'h28, ALPHA_OPAQUE, 1'b0, 1'b1);
    add_pixel(8'h11, 8'h22, 8'h33, 8'h01, 1'b0, 1'b0);
    add_pixel(8'h44, 8'h55, 8'h66, 8'hFE, 1'b1, 1'b0);
    // fifteen distinct colors fill the palette, the sixteenth overflows
    for (int k = 0; k < 16; k++)
      add_pixel({k[4:0], 3'b111}, 8'h80, 8'h40, ALPHA_OPAQUE, k == 15, k == 0);

    // random tiles
    rand_count = 0;
    while (rand_count < RANDOM_PIXELS) begin
      mode  = $urandom_range(99);
      drain = ($urandom_range(9) == 0);
      if (mode < 70) begin
        pool_n = $urandom_range(8, 1);
        len    = $urandom_range(20, 1);
      end else if (mode < 85) begin
        pool_n = $urandom_range(20, 12);
        len    = $urandom_range(32, 14);
      end else begin
        pool_n = 0;
        len    = $urandom_range(12, 1);
      end
      for (int k = 0; k < pool_n; k++) pool[k] = 24'($urandom);
      for (int p = 0; p < len; p++) begin
        if (pool_n == 0) begin
          // noise: any color, any alpha
          c = 24'($urandom);
          pick = $urandom_range(2);
          a = (pick == 0) ? ALPHA_CLEAR : (pick == 1) ? ALPHA_OPAQUE : 8'($urandom);
        end else begin
          c = (p < pool_n) ? pool[p] : pool[$urandom_range(pool_n - 1)];
          pick = $urandom_range(99);
          a = (pick < 8) ? ALPHA_CLEAR :
              (pick == 8) ? 8'($urandom_range(254, 1)) : ALPHA_OPAQUE;
        end
        // low bits vary but must not matter
        add_pixel({c[23:19], 3'($urandom)}, {c[15:11], 3'($urandom)},
                  {c[7:3], 3'($urandom)}, a, p == len - 1, drain && p == 0);
      end
      rand_count += len;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    #0.5 rst_n = 1'b1;

    while (pixel_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d pixels in %0d tiles, %0d result items, %0d palette entries",
             pixels_seen, tiles_seen, results_seen, entries_seen);
    $display("tiles ending in error: %0d bad alpha, %0d palette overflow; %0d mismatches",
             bad_alpha_tiles, overflow_tiles, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** tile_palette_indexer: PASSED **");
    end else begin
      $display("** tile_palette_indexer: FAILED **");
    end
    $finish;
  end

  // watchdog on handshake progress
  initial begin
    do @(posedge clk); while (stuck_cycles < WATCHDOG_CYCLES);
    $display("no item moved for %0d cycles, %0d results still expected",
             WATCHDOG_CYCLES, expected_q.size());
    $display("** tile_palette_indexer: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/tpi_pkg.sv
hdl/tpi_palette.sv
hdl/tile_palette_indexer.sv
hdl/tpi_checker.sv
sim/tb_top.sv
